/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while the block is out of reset.
`define MBR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked at every edge, including the reset cycles.
`define MBR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mbr_pkg.sv */
// Package with constants, register codes and word field positions of the bitmap scaler.
package mbr_pkg;

  localparam int MBR_MAX_WIDTH = 256;
  localparam int MBR_MAX_SCALE = 16;
  localparam int MBR_MAX_HEIGHT = 256;

  localparam int BYTE_BITS = 8;
  localparam int BYTE_SHIFT = 3;
  localparam logic [2:0] BIT_MSB = 3'd7;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int GEOM_W = 9;
  localparam int SCALE_W = 5;
  localparam int COLOR_W = 16;

  // Register codes, taken from the byte address bits [4:2].
  typedef enum logic [2:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_SCALE_X  = 3'd2,
    REG_SCALE_Y  = 3'd3,
    REG_COLOR_FG = 3'd4,
    REG_COLOR_BG = 3'd5
  } mbr_reg_t;

  // Input action carried in in_tuser.
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EMIT = 1'b1
  } mbr_act_t;

  // Bit positions inside out_tuser.
  localparam int OUT_USER_FRAME_END = 0;
  localparam int OUT_USER_STATUS = 1;

endpackage

/* rtl/mbr_row_buf.sv */
// Single-row byte buffer with one write port and one registered read port.
module mbr_row_buf #(
  parameter int DEPTH = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/mono_bitmap_to_rgb565_scaler_unit.sv */
// Top level of the monochrome bitmap to RGB565 expander with integer scaling.
//
//  channel | direction | handshake         | contents
//  in_     | slave     | tvalid/tready     | tdata: data_byte; tuser: action
//  out_    | master    | tvalid/tready     | tdata: pixel; tlast: row_end;
//          |           |                   | tuser: frame_end, status
//  cfg_    | slave     | APB, pready tied  | six registers at byte address 4*i
//
// One word is accepted every cycle while the output side keeps up. An emit word
// comes out behind the buffer read register and the output register; a load word
// produces nothing. Reset is synchronous, active low, clears the counters and
// valid flags and restores the register defaults; the row buffer is not cleared.
// With out_tready low, in_tready drops once one result waits in the output
// register and one more in the read stage.
module mono_bitmap_to_rgb565_scaler_unit
  import mbr_pkg::*;
#(
  parameter int MAX_WIDTH = MBR_MAX_WIDTH,
  parameter int MAX_SCALE = MBR_MAX_SCALE
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input stream.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  input  logic [0:0]        in_tuser,   // [0] action
  // Result stream.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [15:0] pixel
  output logic              out_tlast,
  output logic [1:0]        out_tuser,  // [0] frame_end, [1] status
  // Configuration port.
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // Buffer depth in bytes and the counter widths that follow from the limits.
  localparam int STORE_DEPTH = (MAX_WIDTH + BYTE_BITS - 1) / BYTE_BITS;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int BW = $clog2(STORE_DEPTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int SW = $clog2(MAX_SCALE + 1);

  // Side information that travels with an emit word through the read stage.
  typedef struct packed {
    logic       status;
    logic       row_end;
    logic       frame_end;
    logic [2:0] bit_sel;
  } tag_t;

  // Configuration registers.
  logic [GEOM_W-1:0]  width_r, height_r;
  logic [SCALE_W-1:0] scale_x_r, scale_y_r;
  logic [COLOR_W-1:0] color_fg_r, color_bg_r;

  // Position counters.
  logic [BW-1:0] bytes_loaded_r, bytes_loaded_nxt;
  logic [CW-1:0] column_r, column_nxt;
  logic [RW-1:0] rep_x_r, rep_x_nxt;
  logic [RW-1:0] rep_y_r, rep_y_nxt;
  logic [7:0]    row_r, row_nxt;

  // Read stage and output register.
  logic          s1_valid_r, s1_valid_nxt;
  tag_t          s1_tag_r, s1_tag_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_pixel_r;
  logic          out_row_end_r, out_frame_end_r, out_status_r;

  logic          cfg_wr;
  mbr_reg_t      cfg_idx;
  logic          in_acc, s1_adv;
  logic          is_emit, is_load;
  logic [WW-1:0] eff_w;
  logic [8:0]    eff_h;
  logic [SW-1:0] eff_sx, eff_sy;
  logic [BW-1:0] row_bytes;
  logic          row_ready;
  logic [CW-1:0] col0;
  logic [RW-1:0] rx0, ry0;
  logic [7:0]    row0;
  logic [SW-1:0] rx_inc, ry_inc;
  logic [WW-1:0] col_inc;
  logic [8:0]    row_inc;
  logic          wrap_x, wrap_c, wrap_y, wrap_r;
  logic          buf_wr, buf_rd;
  logic [AW-1:0] buf_raddr;
  logic [7:0]    buf_rdata;
  logic [15:0]   pixel_sel;

  // ---------------------------------------------------------------------------
  // Configuration port. Every access completes in its access cycle.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx = mbr_reg_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= GEOM_W'(8);
      height_r   <= GEOM_W'(8);
      scale_x_r  <= SCALE_W'(1);
      scale_y_r  <= SCALE_W'(1);
      color_fg_r <= '1;
      color_bg_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:    width_r    <= cfg_pwdata[GEOM_W-1:0];
        REG_HEIGHT:   height_r   <= cfg_pwdata[GEOM_W-1:0];
        REG_SCALE_X:  scale_x_r  <= cfg_pwdata[SCALE_W-1:0];
        REG_SCALE_Y:  scale_y_r  <= cfg_pwdata[SCALE_W-1:0];
        REG_COLOR_FG: color_fg_r <= cfg_pwdata[COLOR_W-1:0];
        REG_COLOR_BG: color_bg_r <= cfg_pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:    cfg_prdata = CFG_DW'(width_r);
      REG_HEIGHT:   cfg_prdata = CFG_DW'(height_r);
      REG_SCALE_X:  cfg_prdata = CFG_DW'(scale_x_r);
      REG_SCALE_Y:  cfg_prdata = CFG_DW'(scale_y_r);
      REG_COLOR_FG: cfg_prdata = CFG_DW'(color_fg_r);
      REG_COLOR_BG: cfg_prdata = CFG_DW'(color_bg_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective geometry. Register values outside the legal range are pinned to
  // the nearest limit so that the counters always see a usable bound.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end

    if (height_r == '0) begin
      eff_h = 9'd1;
    end else if (32'(height_r) > MBR_MAX_HEIGHT) begin
      eff_h = 9'(MBR_MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end

    if (scale_x_r == '0) begin
      eff_sx = SW'(1);
    end else if (32'(scale_x_r) > MAX_SCALE) begin
      eff_sx = SW'(MAX_SCALE);
    end else begin
      eff_sx = SW'(scale_x_r);
    end

    if (scale_y_r == '0) begin
      eff_sy = SW'(1);
    end else if (32'(scale_y_r) > MAX_SCALE) begin
      eff_sy = SW'(MAX_SCALE);
    end else begin
      eff_sy = SW'(scale_y_r);
    end
  end

  // Bytes per source row, rounded up to whole bytes.
  assign row_bytes = BW'(({1'b0, eff_w} + (WW + 1)'(BYTE_BITS - 1)) >> BYTE_SHIFT);
  assign row_ready = (bytes_loaded_r >= row_bytes);

  // ---------------------------------------------------------------------------
  // Handshake. The read stage moves on whenever the output register is free
  // or being emptied, and a new word enters whenever the read stage moves on
  // or is empty.
  // ---------------------------------------------------------------------------
  assign s1_adv = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | s1_adv;
  assign in_acc = in_tvalid & in_tready;
  assign is_emit = in_acc & (mbr_act_t'(in_tuser[0]) == ACT_EMIT);
  assign is_load = in_acc & (mbr_act_t'(in_tuser[0]) == ACT_LOAD);

  // ---------------------------------------------------------------------------
  // Position counters. Any counter that sits at or past a limit lowered by a
  // register write restarts at zero before it is used.
  // ---------------------------------------------------------------------------
  always_comb begin
    col0 = (WW'(column_r) >= eff_w) ? '0 : column_r;
    rx0  = (SW'(rep_x_r) >= eff_sx) ? '0 : rep_x_r;
    ry0  = (SW'(rep_y_r) >= eff_sy) ? '0 : rep_y_r;
    row0 = ({1'b0, row_r} >= eff_h) ? '0 : row_r;

    rx_inc  = SW'(rx0) + SW'(1);
    ry_inc  = SW'(ry0) + SW'(1);
    col_inc = WW'(col0) + WW'(1);
    row_inc = {1'b0, row0} + 9'd1;

    wrap_x = (rx_inc >= eff_sx);
    wrap_c = (col_inc >= eff_w);
    wrap_y = (ry_inc >= eff_sy);
    wrap_r = (row_inc >= eff_h);

    bytes_loaded_nxt = bytes_loaded_r;
    column_nxt = column_r;
    rep_x_nxt = rep_x_r;
    rep_y_nxt = rep_y_r;
    row_nxt = row_r;

    if (is_load && !row_ready) begin
      bytes_loaded_nxt = bytes_loaded_r + BW'(1);
    end

    if (is_emit && row_ready) begin
      rep_x_nxt  = wrap_x ? '0 : RW'(rx_inc);
      column_nxt = col0;
      rep_y_nxt  = ry0;
      row_nxt    = row0;
      if (wrap_x) begin
        column_nxt = wrap_c ? '0 : CW'(col_inc);
        if (wrap_c) begin
          rep_y_nxt = wrap_y ? '0 : RW'(ry_inc);
          if (wrap_y) begin
            // The buffered row has been replayed enough times: ask for the next.
            bytes_loaded_nxt = '0;
            row_nxt = wrap_r ? '0 : row_inc[7:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_loaded_r <= '0;
      column_r <= '0;
      rep_x_r <= '0;
      rep_y_r <= '0;
      row_r <= '0;
    end else begin
      bytes_loaded_r <= bytes_loaded_nxt;
      column_r <= column_nxt;
      rep_x_r <= rep_x_nxt;
      rep_y_r <= rep_y_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Row buffer. Loads beyond the row's byte count are dropped. An emit reads
  // only when the row is complete, so every byte it reads was written earlier.
  // ---------------------------------------------------------------------------
  assign buf_wr = is_load & ~row_ready;
  assign buf_rd = is_emit & row_ready;
  assign buf_raddr = AW'(col0 >> BYTE_SHIFT);

  mbr_row_buf #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_row_buf (
    .clk     (clk),
    .wr_en   (buf_wr),
    .wr_addr (bytes_loaded_r[AW-1:0]),
    .wr_data (in_tdata),
    .rd_en   (buf_rd),
    .rd_addr (buf_raddr),
    .rd_data (buf_rdata)
  );

  // ---------------------------------------------------------------------------
  // Read stage: holds the flags of an emit word while its byte is read.
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_tag_nxt.status    = ~row_ready;
    s1_tag_nxt.row_end   = row_ready & wrap_x & wrap_c;
    s1_tag_nxt.frame_end = row_ready & wrap_x & wrap_c & wrap_y & wrap_r;
    s1_tag_nxt.bit_sel   = col0[2:0];
    s1_valid_nxt = is_emit | (s1_valid_r & ~s1_adv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_emit) begin
      s1_tag_r <= s1_tag_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. A not-ready result carries a zero pixel.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (s1_tag_r.status) begin
      pixel_sel = '0;
    end else if (buf_rdata[BIT_MSB - s1_tag_r.bit_sel]) begin
      pixel_sel = color_fg_r;
    end else begin
      pixel_sel = color_bg_r;
    end
    out_valid_nxt = s1_adv | (out_valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pixel_r     <= pixel_sel;
      out_row_end_r   <= s1_tag_r.row_end;
      out_frame_end_r <= s1_tag_r.frame_end;
      out_status_r    <= s1_tag_r.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_pixel_r;
  assign out_tlast = out_row_end_r;
  assign out_tuser[OUT_USER_FRAME_END] = out_frame_end_r;
  assign out_tuser[OUT_USER_STATUS] = out_status_r;

endmodule

/* rtl/mbr_checker.sv */
// Port-level checker for the bitmap scaler and its bind statement.
`include "assert_macros.svh"

module mbr_checker
  import mbr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  logic        stalled;
  logic [18:0] out_word;
  logic        nr_word;
  logic        out_marks;
  logic        frame_word;

  assign stalled    = out_tvalid && !out_tready;
  assign out_word   = {out_tdata, out_tlast, out_tuser};
  assign nr_word    = out_tvalid && out_tuser[OUT_USER_STATUS];
  assign out_marks  = out_tlast || out_tuser[OUT_USER_FRAME_END];
  assign frame_word = out_tvalid && out_tuser[OUT_USER_FRAME_END];

  // Nothing is offered in the cycle after a reset cycle.
  `MBR_ASSERT_ALWAYS(a_idle_after_reset, clk, !rst_n |=> !out_tvalid, "word offered after reset")

  // A stalled result stays offered and unchanged.
  `MBR_ASSERT(a_hold, clk, rst_n, stalled |=> out_tvalid && $stable(out_word), "word not held")

  // A not-ready result carries a zero pixel and no end marks.
  `MBR_ASSERT(a_nr_clean, clk, rst_n, nr_word |-> ~|out_tdata && !out_marks, "not-ready data")

  // The end of the bitmap is always also the end of an output row.
  `MBR_ASSERT(a_frame_ends_row, clk, rst_n, frame_word |-> out_tlast, "frame end not at row end")

endmodule

bind mono_bitmap_to_rgb565_scaler_unit mbr_checker u_mbr_checker (.*);

/* bench/tb_top.sv */
// Self-checking testbench for the monochrome bitmap to RGB565 scaler unit.
module tb_top
  import mbr_pkg::*;
();

  // One result word as the scoreboard sees it: pixel, row end, frame end, status.
  typedef struct packed {
    logic [COLOR_W-1:0] pixel;
    logic               row_end;
    logic               frame_end;
    logic               status;
  } pixel_word_t;

  // Keeps its own copy of the registers and the row counters. Every accepted
  // input word updates that copy, and every emit queues the pixel word the
  // block has to return.
  class pixel_scoreboard;
    logic [GEOM_W-1:0]  width_reg;
    logic [GEOM_W-1:0]  height_reg;
    logic [SCALE_W-1:0] scale_x_reg;
    logic [SCALE_W-1:0] scale_y_reg;
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic [7:0]         row_buf [MBR_MAX_WIDTH/BYTE_BITS];
    int unsigned        loaded;
    int unsigned        column;
    int unsigned        rep_x;
    int unsigned        rep_y;
    int unsigned        src_row;
    pixel_word_t        pending_pixels [$];
    int unsigned        mismatches;

    function new();
      width_reg   = 9'd8;
      height_reg  = 9'd8;
      scale_x_reg = 5'd1;
      scale_y_reg = 5'd1;
      fg_reg      = 16'hFFFF;
      bg_reg      = 16'h0000;
      loaded      = 0;
      column      = 0;
      rep_x       = 0;
      rep_y       = 0;
      src_row     = 0;
      mismatches  = 0;
    endfunction

    // Register values outside 1..hi are treated as the nearest bound.
    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned eff_width();
      return clamp(width_reg, MBR_MAX_WIDTH);
    endfunction

    function int unsigned eff_height();
      return clamp(height_reg, MBR_MAX_HEIGHT);
    endfunction

    function int unsigned eff_scale_x();
      return clamp(scale_x_reg, MBR_MAX_SCALE);
    endfunction

    function int unsigned eff_scale_y();
      return clamp(scale_y_reg, MBR_MAX_SCALE);
    endfunction

    function int unsigned bytes_per_row();
      return (eff_width() + BYTE_BITS - 1) / BYTE_BITS;
    endfunction

    function void set_reg(mbr_reg_t r, logic [CFG_DW-1:0] v);
      case (r)
        REG_WIDTH:    width_reg = v[GEOM_W-1:0];
        REG_HEIGHT:   height_reg = v[GEOM_W-1:0];
        REG_SCALE_X:  scale_x_reg = v[SCALE_W-1:0];
        REG_SCALE_Y:  scale_y_reg = v[SCALE_W-1:0];
        REG_COLOR_FG: fg_reg = v[COLOR_W-1:0];
        REG_COLOR_BG: bg_reg = v[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(mbr_act_t act, logic [7:0] data);
      pixel_word_t res;
      logic [7:0]  src_byte;
      int unsigned w;
      int unsigned h;
      int unsigned sx;
      int unsigned sy;
      w  = eff_width();
      h  = eff_height();
      sx = eff_scale_x();
      sy = eff_scale_y();
      res = '0;
      if (act == ACT_LOAD) begin
        // Bytes beyond the row's byte count are dropped.
        if (loaded < bytes_per_row()) begin
          row_buf[loaded] = data;
          loaded++;
        end
        return;
      end
      if (loaded < bytes_per_row()) begin
        // Row not complete yet: status only, nothing moves.
        res.status = 1'b1;
        pending_pixels.push_back(res);
        return;
      end
      // A register change can leave counters past their new limits.
      if (column >= w) column = 0;
      if (rep_x >= sx) rep_x = 0;
      if (rep_y >= sy) rep_y = 0;
      if (src_row >= h) src_row = 0;
      src_byte  = row_buf[column / BYTE_BITS];
      res.pixel = src_byte[BIT_MSB - 3'(column % BYTE_BITS)] ? fg_reg : bg_reg;
      rep_x++;
      if (rep_x >= sx) begin
        rep_x = 0;
        column++;
        if (column >= w) begin
          column = 0;
          res.row_end = 1'b1;
          rep_y++;
          if (rep_y >= sy) begin
            rep_y  = 0;
            loaded = 0;
            src_row++;
            if (src_row >= h) begin
              src_row = 0;
              res.frame_end = 1'b1;
            end
          end
        end
      end
      pending_pixels.push_back(res);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      mismatches++;
      $display("pixel check: %s is %0h, expected %0h", what, got, want);
    endtask

    task check_result(pixel_word_t got);
      pixel_word_t want;
      if (pending_pixels.size() == 0) begin
        report("word with nothing pending", got, 0);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel != want.pixel) report("pixel", got.pixel, want.pixel);
      if (got.row_end != want.row_end) report("row_end", got.row_end, want.row_end);
      if (got.frame_end != want.frame_end) report("frame_end", got.frame_end, want.frame_end);
      if (got.status != want.status) report("status", got.status, want.status);
    endtask
  endclass

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = 8'h00;   // [7:0] data_byte
  logic [0:0]        in_tuser = 1'b0;    // [0] action
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;          // [15:0] pixel
  logic              out_tlast;
  logic [1:0]        out_tuser;          // [0] frame_end, [1] status
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  pixel_scoreboard sb;
  int unsigned     words_sent = 0;
  // While set, neither side idles.
  bit              calm = 1'b0;

  mono_bitmap_to_rgb565_scaler_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Outside calm phases the receiver stalls in about a third of the cycles.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 34);
  end

  // Both channels are sampled at the edge, before any driver update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_word(mbr_act_t'(in_tuser[0]), in_tdata);
      if (out_tvalid && out_tready)
        sb.check_result({out_tdata, out_tlast, out_tuser[OUT_USER_FRAME_END],
                         out_tuser[OUT_USER_STATUS]});
    end
  end

  // Bytes lean toward all-clear and all-set rows so both colors show up in runs.
  function automatic logic [7:0] random_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offers one word and holds it until the block takes it, then idles at random.
  task automatic push_word(mbr_act_t act, logic [7:0] data);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    while (!calm && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Holds the sender back until every pending pixel has come out, then lets
  // the two pipeline stages settle so that a trailing load has landed.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Writes all six registers, each with a setup and an access cycle. psel stays
  // high between writes so no cycle sees it dropped and raised at once.
  task automatic program_regs(int unsigned w, int unsigned h, int unsigned sx,
                              int unsigned sy, int unsigned fg, int unsigned bg);
    mbr_reg_t    regs [6];
    int unsigned vals [6];
    regs = '{REG_WIDTH, REG_HEIGHT, REG_SCALE_X, REG_SCALE_Y, REG_COLOR_FG, REG_COLOR_BG};
    vals = '{w, h, sx, sy, fg, bg};
    for (int i = 0; i < 6; i++) begin
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= {regs[i], 2'b00};
      cfg_pwdata  <= vals[i];
      @(posedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // One source row: its bytes, now and then a premature emit among them or
  // surplus loads after them, then every output pixel the row expands into.
  // Outside whole frames, stray words break the pattern and the row stops
  // at the word budget.
  task automatic send_row(bit whole, int unsigned stop_at);
    int unsigned rb;
    int unsigned n_emit;
    int unsigned early;
    rb     = sb.bytes_per_row();
    n_emit = sb.eff_width() * sb.eff_scale_x() * sb.eff_scale_y();
    early  = ($urandom_range(9) == 0) ? $urandom_range(rb - 1) : rb;
    for (int unsigned i = 0; i < rb; i++) begin
      if (i == early) push_word(ACT_EMIT, random_byte());
      push_word(ACT_LOAD, random_byte());
    end
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 2)) push_word(ACT_LOAD, random_byte());
    for (int unsigned e = 0; e < n_emit && (whole || words_sent < stop_at); e++) begin
      if (!whole && $urandom_range(24) == 0)
        push_word(mbr_act_t'($urandom_range(1)), random_byte());
      push_word(ACT_EMIT, random_byte());
    end
  endtask

  // A budget of zero asks for one whole frame. Otherwise small frames are run
  // whole at random, and all others are cut off wherever the budget ends, which
  // leaves counters mid-row for the next register change.
  task automatic run_phase(int unsigned w, int unsigned h, int unsigned sx, int unsigned sy,
                           int unsigned fg, int unsigned bg, int unsigned budget);
    int unsigned frame_words;
    int unsigned stop_at;
    bit          whole;
    drain();
    program_regs(w, h, sx, sy, fg, bg);
    frame_words = sb.eff_height() *
                  (sb.bytes_per_row() + sb.eff_width() * sb.eff_scale_x() * sb.eff_scale_y());
    whole   = (budget == 0) || (frame_words <= 250 && $urandom_range(1) == 1);
    stop_at = words_sent + budget;
    if (whole) begin
      repeat (sb.eff_height()) send_row(1'b1, 0);
    end else begin
      while (words_sent < stop_at) begin
        if ($urandom_range(19) == 0) drain();
        send_row(1'b0, stop_at);
      end
    end
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned sx;
    int unsigned sy;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset settings: an 8-pixel row of one byte.
    push_word(ACT_EMIT, 8'hA5);          // nothing loaded: not ready
    push_word(ACT_LOAD, 8'h81);          // leftmost and rightmost pixels set
    push_word(ACT_LOAD, 8'hFF);          // the row holds one byte, so this is dropped
    repeat (8) push_word(ACT_EMIT, 8'h00);
    push_word(ACT_EMIT, 8'hFF);          // row used up: not ready again
    push_word(ACT_LOAD, 8'h7E);
    repeat (8) push_word(ACT_EMIT, 8'h5A);

    // The widest row, with no idling on either side.
    calm <= 1'b1;
    run_phase(256, 1, 1, 1, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF), 0);
    calm <= 1'b0;
    // Width zero and an oversized height saturate to 1 and 256 rows.
    run_phase(0, 511, 1, 1, 16'h0000, 16'hFFFF, 0);
    // Largest repeat both ways, the horizontal one written out of range.
    run_phase(1, 1, 31, 16, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF), 0);
    // Oversized width with zero height and scales, cut off mid-row.
    run_phase(511, 0, 0, 0, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF), 120);

    while (words_sent < 1480) begin
      w  = ($urandom_range(9) == 0) ? $urandom_range(511) :
           ($urandom_range(3) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
      h  = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 4);
      sx = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 3);
      sy = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 3);
      run_phase(w, h, sx, sy, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                $urandom_range(80, 200));
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
